// ===== rtl/lcht_pkg.sv =====
// Package for the LRU cache hit tracker: sizes, register codes and the
// struct types passed between the configuration block, the cells and the top.
// No dependencies.
`timescale 1ns / 1ps

package lcht_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int LS_W        = 4;
  localparam int ACT_W       = 9;
  localparam int LIM_W       = (CNT_W > ACT_W) ? CNT_W : ACT_W;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [LS_W-1:0]  LS_MAX    = 4'd12;
  localparam logic [LS_W-1:0]  LS_RESET  = 4'd6;
  localparam logic [ACT_W-1:0] ACT_RESET = 9'd256;

  // Register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_LINE_SIZE = 1'b0,
    REG_ACTIVE    = 1'b1
  } reg_idx_e;

  // Settings seen by the datapath
  typedef struct packed {
    logic [ADDR_W-1:0] line_mask;
    logic [LIM_W-1:0]  limit;
  } cfg_t;

  // One access travelling down the chain
  typedef struct packed {
    logic              vld;
    logic              act;    // carry still looking for a home
    logic              found;
    logic [ADDR_W-1:0] key;
    logic [ADDR_W-1:0] carry;
  } wave_t;

endpackage

// ===== rtl/lcht_if.sv =====
// Stream interfaces for the LRU cache hit tracker: access beats in,
// result beats out. Depends on lcht_pkg.
`timescale 1ns / 1ps

interface lcht_in_if;
  logic                       valid;
  logic                       ready;
  logic [lcht_pkg::ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface lcht_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [lcht_pkg::ADDR_W-1:0] line_address;

  modport source (output valid, output hit, output line_address, input ready);
  modport sink   (input valid, input hit, input line_address, output ready);
endinterface

// ===== rtl/lcht_cfg.sv =====
// APB register block: line size and active entry count, decoded into the
// line mask and the fill limit used by the cell chain. Depends on lcht_pkg.
`timescale 1ns / 1ps

module lcht_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcht_pkg::PADDR_W-1:0]  paddr,
  input  logic [lcht_pkg::PDATA_W-1:0]  pwdata,
  output logic [lcht_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output lcht_pkg::cfg_t                cfg_o
);

  logic [lcht_pkg::LS_W-1:0]  line_size_q, line_size_d;
  logic [lcht_pkg::ACT_W-1:0] active_q, active_d;
  lcht_pkg::reg_idx_e         reg_idx;
  logic                       wr_en;
  logic [lcht_pkg::LS_W-1:0]  ls_clamped;

  assign pready  = 1'b1;
  assign reg_idx = lcht_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    line_size_d = line_size_q;
    active_d    = active_q;
    prdata      = '0;
    unique case (reg_idx)
      lcht_pkg::REG_LINE_SIZE: begin
        prdata = lcht_pkg::PDATA_W'(line_size_q);
        if (wr_en) begin
          line_size_d = pwdata[lcht_pkg::LS_W-1:0];
        end
      end
      lcht_pkg::REG_ACTIVE: begin
        prdata = lcht_pkg::PDATA_W'(active_q);
        if (wr_en) begin
          active_d = pwdata[lcht_pkg::ACT_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_size_q <= lcht_pkg::LS_RESET;
      active_q    <= lcht_pkg::ACT_RESET;
    end else begin
      line_size_q <= line_size_d;
      active_q    <= active_d;
    end
  end

  // Line sizes above the maximum act as the maximum; zero entries act as one
  assign ls_clamped = (line_size_q > lcht_pkg::LS_MAX) ? lcht_pkg::LS_MAX : line_size_q;

  always_comb begin
    cfg_o.line_mask = ~((lcht_pkg::ADDR_W'(1) << ls_clamped) - lcht_pkg::ADDR_W'(1));
    cfg_o.limit     = (active_q == '0) ? lcht_pkg::LIM_W'(1) : lcht_pkg::LIM_W'(active_q);
  end

endmodule

// ===== rtl/lcht_cell.sv =====
// One recency slot of the LRU stack: holds a line tag, compares it with the
// passing access and swaps in the carried tag. Depends on lcht_pkg.
`timescale 1ns / 1ps

module lcht_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [lcht_pkg::IDX_W-1:0]  cell_idx_i,
  input  logic [lcht_pkg::LIM_W-1:0]  limit_i,
  input  lcht_pkg::wave_t             wave_i,
  output lcht_pkg::wave_t             wave_o,
  output logic                        valid_o
);

  logic [lcht_pkg::ADDR_W-1:0] tag_q, tag_d;
  logic                        valid_q, valid_d;
  lcht_pkg::wave_t             wave_q, wave_d;
  logic                        wave_vld_q;

  always_comb begin
    wave_d  = wave_i;
    tag_d   = tag_q;
    valid_d = valid_q;
    if (wave_i.vld && wave_i.act) begin
      if (valid_q) begin
        tag_d = wave_i.carry;
        if (tag_q == wave_i.key) begin
          // hit: the matching line is overwritten by the carry, stop here
          wave_d.act   = 1'b0;
          wave_d.found = 1'b1;
        end else begin
          wave_d.carry = tag_q;
        end
      end else begin
        // first empty slot: fill if under the limit, else drop the oldest line
        wave_d.act = 1'b0;
        if (lcht_pkg::LIM_W'(cell_idx_i) < limit_i) begin
          tag_d   = wave_i.carry;
          valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      wave_vld_q <= 1'b0;
    end else if (adv_i) begin
      valid_q    <= valid_d;
      wave_vld_q <= wave_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q  <= tag_d;
      wave_q <= wave_d;
    end
  end

  always_comb begin
    wave_o     = wave_q;
    wave_o.vld = wave_vld_q;
  end

  assign valid_o = valid_q;

endmodule

// ===== rtl/lru_cache_hit_tracker_top.sv =====
// LRU cache hit tracker: a chain of MAX_ENTRIES cells ordered by recency.
// Each access passes through every cell register in turn to its result beat; stalls hold it.
// Accesses move down the cell chain with one empty cell between each two, so
// no access is taken right behind another; a stalled result beat freezes the chain.
// Reset: cache empty, line size 64 bytes, 256 active entries; no clearing pass.
// Depends on lcht_pkg, lcht_if, lcht_cfg and lcht_cell.
`timescale 1ns / 1ps

module lru_cache_hit_tracker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lcht_in_if.sink                       in_i,
  lcht_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcht_pkg::PADDR_W-1:0]  paddr,
  input  logic [lcht_pkg::PDATA_W-1:0]  pwdata,
  output logic [lcht_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  lcht_pkg::cfg_t                      cfg;
  lcht_pkg::wave_t                     chain [lcht_pkg::MAX_ENTRIES+1];
  logic [lcht_pkg::MAX_ENTRIES-1:0]    vld_vec;
  logic                                adv;
  logic                                accept;
  logic                                gap_q;
  logic [lcht_pkg::ADDR_W-1:0]         line;

  lcht_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Hold the whole chain while the result beat waits
  assign adv        = !chain[lcht_pkg::MAX_ENTRIES].vld || out_o.ready;
  assign in_i.ready = adv && !gap_q;
  assign accept     = in_i.valid && in_i.ready;
  assign line       = in_i.address & cfg.line_mask;

  always_comb begin
    chain[0].vld   = accept;
    chain[0].act   = 1'b1;
    chain[0].found = 1'b0;
    chain[0].key   = line;
    chain[0].carry = line;
  end

  // Leave one empty slot behind each access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 1'b0;
    end else if (adv) begin
      gap_q <= accept;
    end
  end

  for (genvar i = 0; i < lcht_pkg::MAX_ENTRIES; i++) begin : g_cell
    lcht_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cell_idx_i (lcht_pkg::IDX_W'(i)),
      .limit_i    (cfg.limit),
      .wave_i     (chain[i]),
      .wave_o     (chain[i+1]),
      .valid_o    (vld_vec[i])
    );
  end

  assign out_o.valid        = chain[lcht_pkg::MAX_ENTRIES].vld;
  assign out_o.hit          = chain[lcht_pkg::MAX_ENTRIES].found;
  assign out_o.line_address = chain[lcht_pkg::MAX_ENTRIES].key;

  a_spacing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("two accesses accepted in adjacent cycles");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("access accepted while the chain is stalled");

  a_hit_resolved : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.hit |-> !chain[lcht_pkg::MAX_ENTRIES].act)
    else $error("hit result still carries a line");

  a_occupied_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_vec + lcht_pkg::MAX_ENTRIES'(1)) & vld_vec) == '0)
    else $error("occupied slots are not a contiguous prefix");

endmodule

// ===== dv/lru_cache_hit_tracker_top_tb.sv =====
// Testbench for lru_cache_hit_tracker_top: drives access beats, scores result
// beats against an LRU list kept in the bench, and sets registers over APB.
// Depends on lcht_pkg, lcht_if and the RTL of the top level.
`timescale 1ns / 1ps

module lru_cache_hit_tracker_top_tb;

  localparam int STALL_PCT     = 21;
  localparam int HOLD_CYCLES   = 600;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 300;
  localparam int POOL_MAX      = 512;

  typedef struct packed {
    logic                        hit;
    logic [lcht_pkg::ADDR_W-1:0] line_address;
  } lookup_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [lcht_pkg::PADDR_W-1:0] paddr;
  logic [lcht_pkg::PDATA_W-1:0] pwdata;
  logic [lcht_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  lcht_in_if  in_if ();
  lcht_out_if out_if ();

  lru_cache_hit_tracker_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bench copy of the cache: front is most recent
  logic [lcht_pkg::ADDR_W-1:0] lru_lines[$];
  lookup_t                     expected_results[$];
  logic [lcht_pkg::LS_W-1:0]   cfg_line_log2;
  logic [lcht_pkg::ACT_W-1:0]  cfg_active;

  bit          calm;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned err_cnt;
  int unsigned n_hits;
  int unsigned n_misses;
  int unsigned n_settings;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [lcht_pkg::ADDR_W-1:0] offset_mask();
    logic [lcht_pkg::LS_W-1:0] k;
    k = (cfg_line_log2 > lcht_pkg::LS_MAX) ? lcht_pkg::LS_MAX : cfg_line_log2;
    return (64'd1 << k) - 64'd1;
  endfunction

  function automatic void predict_lookup(input logic [lcht_pkg::ADDR_W-1:0] addr);
    logic [lcht_pkg::ADDR_W-1:0] line;
    int unsigned                 lim;
    int                          pos;
    lookup_t                     res;
    line = addr & ~offset_mask();
    lim  = (cfg_active == 0) ? 1 :
           ((cfg_active > lcht_pkg::MAX_ENTRIES) ? lcht_pkg::MAX_ENTRIES : cfg_active);
    pos  = -1;
    foreach (lru_lines[i]) begin
      if (pos < 0 && lru_lines[i] == line) pos = i;
    end
    // Miss at or above the limit drops exactly one line, so a lowered limit never shrinks
    if (pos >= 0) lru_lines.delete(pos);
    else if (lru_lines.size() >= lim) lru_lines.delete(lru_lines.size() - 1);
    lru_lines.insert(0, line);
    res.hit          = (pos >= 0);
    res.line_address = line;
    expected_results.push_back(res);
  endfunction

  task automatic send_access(input logic [lcht_pkg::ADDR_W-1:0] addr);
    while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.address <= addr;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_lookup(addr);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input lcht_pkg::reg_idx_e r,
                            input logic [lcht_pkg::PDATA_W-1:0] wdata,
                            output logic [lcht_pkg::PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write one register with junk above its field, then read it back
  task automatic set_config(input lcht_pkg::reg_idx_e r,
                            input logic [lcht_pkg::ACT_W-1:0] v);
    logic [lcht_pkg::PDATA_W-1:0] wdata;
    logic [lcht_pkg::PDATA_W-1:0] rdata;
    if (r == lcht_pkg::REG_LINE_SIZE)
      wdata = ($urandom & ~32'hF) | lcht_pkg::PDATA_W'(v[lcht_pkg::LS_W-1:0]);
    else
      wdata = ($urandom & ~32'h1FF) | lcht_pkg::PDATA_W'(v);
    apb_access(1'b1, r, wdata, rdata);
    apb_access(1'b0, r, '0, rdata);
    if (r == lcht_pkg::REG_LINE_SIZE) begin
      cfg_line_log2 = v[lcht_pkg::LS_W-1:0];
      if (rdata[lcht_pkg::LS_W-1:0] !== v[lcht_pkg::LS_W-1:0]) begin
        $error("line_size_log2: expected %0d, got %0d", v[lcht_pkg::LS_W-1:0],
               rdata[lcht_pkg::LS_W-1:0]);
        err_cnt++;
      end
    end else begin
      cfg_active = v;
      if (rdata[lcht_pkg::ACT_W-1:0] !== v) begin
        $error("active_entries: expected %0d, got %0d", v, rdata[lcht_pkg::ACT_W-1:0]);
        err_cnt++;
      end
    end
    n_settings++;
  endtask

  // Mostly reuse a pool of lines at random offsets so hits and evictions both happen
  task automatic run_lookups(input int n_items, input int pool_size);
    logic [lcht_pkg::ADDR_W-1:0] pool[POOL_MAX];
    logic [lcht_pkg::ADDR_W-1:0] mask;
    logic [lcht_pkg::ADDR_W-1:0] addr;
    for (int i = 0; i < pool_size; i++) pool[i] = {$urandom, $urandom};
    for (int n = 0; n < n_items; n++) begin
      mask = offset_mask();
      if ($urandom_range(0, 99) < 85)
        addr = (pool[$urandom_range(0, pool_size - 1)] & ~mask) | ({$urandom, $urandom} & mask);
      else
        addr = {$urandom, $urandom};
      send_access(addr);
    end
  endtask

  // Reset values and a few lookups with 64-byte lines
  task automatic test_reset_values();
    logic [lcht_pkg::PDATA_W-1:0] rdata;
    apb_access(1'b0, lcht_pkg::REG_LINE_SIZE, '0, rdata);
    if (rdata[lcht_pkg::LS_W-1:0] !== lcht_pkg::LS_RESET) begin
      $error("line_size_log2: expected %0d, got %0d", lcht_pkg::LS_RESET,
             rdata[lcht_pkg::LS_W-1:0]);
      err_cnt++;
    end
    apb_access(1'b0, lcht_pkg::REG_ACTIVE, '0, rdata);
    if (rdata[lcht_pkg::ACT_W-1:0] !== lcht_pkg::ACT_RESET) begin
      $error("active_entries: expected %0d, got %0d", lcht_pkg::ACT_RESET,
             rdata[lcht_pkg::ACT_W-1:0]);
      err_cnt++;
    end
    send_access(64'h0);
    send_access(64'h3F);
    send_access(64'h40);
    send_access('1);
    send_access(64'h0);
    drain_results();
  endtask

  // One-byte lines; zero entries acts as one, with the cache already above that
  task automatic test_narrow_lines_single_entry();
    set_config(lcht_pkg::REG_LINE_SIZE, 9'd0);
    set_config(lcht_pkg::REG_ACTIVE, 9'd0);
    send_access(64'h5555_5555_5555_5555);
    send_access(64'h5555_5555_5555_5555);
    send_access(64'h5555_5555_5555_5554);
    send_access(64'h5555_5555_5555_5555);
    send_access(64'hFFFF_FFFF_FFFF_FFFF);
    drain_results();
  endtask

  // Line size beyond 12 and entries beyond the store both clamp
  task automatic test_wide_lines_clamped();
    set_config(lcht_pkg::REG_LINE_SIZE, 9'd15);
    set_config(lcht_pkg::REG_ACTIVE, 9'd511);
    send_access(64'h1234_5678_9ABC_DFFF);
    send_access(64'h1234_5678_9ABC_D000);
    send_access(64'h1234_5678_9ABC_E000);
    send_access(64'hAAAA_AAAA_AAAA_AAAA);
    send_access(64'h5555_5555_5555_5555);
    drain_results();
    set_config(lcht_pkg::REG_LINE_SIZE, 9'd12);
    set_config(lcht_pkg::REG_ACTIVE, 9'd256);
    send_access(64'h0000_0000_0000_0FFF);
    send_access(64'h0);
    send_access(64'hAAAA_AAAA_AAAA_A000);
    drain_results();
  endtask

  task automatic test_random_settings();
    int unsigned lim;
    set_config(lcht_pkg::REG_LINE_SIZE, 9'd6);
    set_config(lcht_pkg::REG_ACTIVE, 9'd8);
    run_lookups(200, 12);
    drain_results();
    set_config(lcht_pkg::REG_LINE_SIZE, 9'd0);
    set_config(lcht_pkg::REG_ACTIVE, 9'd1);
    run_lookups(100, 3);
    drain_results();
    // Long stretch without any idling on either side
    calm = 1'b1;
    set_config(lcht_pkg::REG_LINE_SIZE, 9'd12);
    set_config(lcht_pkg::REG_ACTIVE, 9'd256);
    run_lookups(200, 300);
    drain_results();
    calm = 1'b0;
    repeat (4) begin
      set_config(lcht_pkg::REG_LINE_SIZE, lcht_pkg::ACT_W'($urandom_range(0, 15)));
      set_config(lcht_pkg::REG_ACTIVE, lcht_pkg::ACT_W'($urandom_range(0, 511)));
      lim = (cfg_active == 0) ? 1 :
            ((cfg_active > lcht_pkg::MAX_ENTRIES) ? lcht_pkg::MAX_ENTRIES : cfg_active);
      run_lookups(100, lim / 2 + $urandom_range(1, lim));
      drain_results();
    end
  endtask

  // Hold the result side off long enough for the chain to fill and stall input
  task automatic test_output_stall();
    set_config(lcht_pkg::REG_LINE_SIZE, 9'd3);
    set_config(lcht_pkg::REG_ACTIVE, 9'd32);
    hold_req++;
    run_lookups(200, 48);
    drain_results();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (calm) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // Score result beats and watch for a stuck run
  always @(posedge clk_i) begin
    lookup_t exp_res;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: hit=%0b line_address=%h", out_if.hit,
               out_if.line_address);
        err_cnt++;
      end else begin
        exp_res = expected_results.pop_front();
        if (exp_res.hit) n_hits++;
        else n_misses++;
        if (out_if.hit !== exp_res.hit) begin
          $error("hit: expected %0b, got %0b", exp_res.hit, out_if.hit);
          err_cnt++;
        end
        if (out_if.line_address !== exp_res.line_address) begin
          $error("line_address: expected %h, got %h", exp_res.line_address,
                 out_if.line_address);
          err_cnt++;
        end
      end
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: %0d cycles without a beat, %0d results outstanding", quiet_cycles,
               expected_results.size());
      $display("lru_cache_hit_tracker_top_tb failed");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_if.valid   <= 1'b0;
    in_if.address <= '0;
    cfg_line_log2 = lcht_pkg::LS_RESET;
    cfg_active    = lcht_pkg::ACT_RESET;
    calm          = 1'b0;
    hold_req      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    err_cnt       = 0;
    n_hits        = 0;
    n_misses      = 0;
    n_settings    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_narrow_lines_single_entry();
    test_wide_lines_clamped();
    test_random_settings();
    test_output_stall();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("checked %0d lookups (%0d hits, %0d misses) across %0d register writes,",
             n_hits + n_misses, n_hits, n_misses, n_settings);
    $display("including clamped line sizes and entry counts and a long output stall");
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("lru_cache_hit_tracker_top_tb passed");
    end else begin
      $display("lru_cache_hit_tracker_top_tb failed");
    end
    $finish;
  end

endmodule
